// ===== sv/clcd_pkg.sv =====
package clcd_pkg;

   // Line buffer sizing.
   localparam int BUFFER_SIZE = 64;
   localparam int LEN_W = $clog2(BUFFER_SIZE);
   localparam int STORED_CHARS = 8;
   localparam int STORE_IDX_W = $clog2(STORED_CHARS);

   // Queue between the line editor and the result sequencer.
   localparam int ACT_DEPTH = 4;
   localparam int ACT_PTR_W = $clog2(ACT_DEPTH);
   localparam int ACT_CNT_W = $clog2(ACT_DEPTH + 1);

   // Request codes.
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_COLOUR = 2'd1;
   localparam logic [1:0] KIND_UNKNOWN = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   // Characters with a special meaning on the console.
   localparam logic [7:0] CHAR_BEL = 8'h07;
   localparam logic [7:0] CHAR_BS = 8'h08;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_DEL = 8'h7F;

   // Command table: text, length and the LED levels it selects.
   localparam int CMD_COUNT = 5;
   localparam int CMD_MAX_LEN = 7;
   localparam int CMD_LEN_W = $clog2(CMD_MAX_LEN + 1);
   localparam logic [7:0] LEVEL_ON = 8'd255;
   localparam logic [7:0] LEVEL_OFF = 8'd0;

   localparam logic [7:0] CMD_TEXT [CMD_COUNT][CMD_MAX_LEN] = '{
      '{"L", "E", "D", "_", "O", "N", 8'h00},
      '{"L", "E", "D", "_", "O", "F", "F"},
      '{"R", "E", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"G", "R", "E", "E", "N", 8'h00, 8'h00},
      '{"B", "L", "U", "E", 8'h00, 8'h00, 8'h00}
   };
   localparam logic [CMD_LEN_W-1:0] CMD_LEN [CMD_COUNT] = '{3'd6, 3'd7, 3'd3, 3'd5, 3'd4};
   localparam logic [7:0] CMD_RED [CMD_COUNT] = '{LEVEL_ON, LEVEL_OFF, LEVEL_ON, LEVEL_OFF,
                                                  LEVEL_OFF};
   localparam logic [7:0] CMD_GREEN [CMD_COUNT] = '{LEVEL_ON, LEVEL_OFF, LEVEL_OFF, LEVEL_ON,
                                                    LEVEL_OFF};
   localparam logic [7:0] CMD_BLUE [CMD_COUNT] = '{LEVEL_ON, LEVEL_OFF, LEVEL_OFF, LEVEL_OFF,
                                                   LEVEL_ON};

   // Work the line editor hands to the result sequencer.
   typedef enum logic [1:0] {
      ACT_ECHO,
      ACT_ERASE,
      ACT_END
   } act_kind_type;

   // Outcome of an ended line.
   typedef enum logic [1:0] {
      VERDICT_NONE,
      VERDICT_COLOUR,
      VERDICT_UNKNOWN,
      VERDICT_REJECT
   } verdict_type;

   typedef struct packed {
      act_kind_type kind;
      logic [7:0] echo_byte;
      verdict_type verdict;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } action_type;

   typedef struct packed {
      logic req_type;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] echo_byte;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic last;
   } rsp_item_type;

endpackage

// ===== sv/clcd_front.sv =====
module clcd_front (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input clcd_pkg::req_item_type req_data,
   output logic act_push,
   output clcd_pkg::action_type act_data,
   input logic act_full
);

   logic [7:0] chars_ff [clcd_pkg::STORED_CHARS];
   logic [clcd_pkg::LEN_W-1:0] length_ff;
   logic [clcd_pkg::LEN_W-1:0] length_in;
   logic overflow_ff;
   logic overflow_in;
   logic skip_ff;
   logic skip_in;
   logic accept;
   logic char_wr;
   logic [7:0] ch;
   logic cmd_found;
   logic [7:0] lvl_red;
   logic [7:0] lvl_green;
   logic [7:0] lvl_blue;
   logic cmd_hit [clcd_pkg::CMD_COUNT];
   clcd_pkg::verdict_type verdict;

   // Every accepted item needs room for one action, whether or not it makes one.
   assign full = act_full;
   assign accept = push && !act_full;
   assign ch = req_data.rx_byte;

   // Compare the held line against each command.
   always_comb begin
      for (int c = 0; c < clcd_pkg::CMD_COUNT; c++) begin
         cmd_hit[c] = (length_ff == clcd_pkg::LEN_W'(clcd_pkg::CMD_LEN[c]));
         for (int i = 0; i < clcd_pkg::CMD_MAX_LEN; i++) begin
            if ((clcd_pkg::CMD_LEN_W'(i) < clcd_pkg::CMD_LEN[c]) &&
                (chars_ff[i] != clcd_pkg::CMD_TEXT[c][i])) begin
               cmd_hit[c] = 1'b0;
            end
         end
      end
   end

   // The first matching command picks the LED levels.
   always_comb begin
      cmd_found = 1'b0;
      lvl_red = '0;
      lvl_green = '0;
      lvl_blue = '0;
      for (int c = 0; c < clcd_pkg::CMD_COUNT; c++) begin
         if (cmd_hit[c] && !cmd_found) begin
            cmd_found = 1'b1;
            lvl_red = clcd_pkg::CMD_RED[c];
            lvl_green = clcd_pkg::CMD_GREEN[c];
            lvl_blue = clcd_pkg::CMD_BLUE[c];
         end
      end
   end

   // Classify the line as it would be ended now.
   always_comb begin
      priority if (overflow_ff) begin
         verdict = clcd_pkg::VERDICT_REJECT;
      end else if (length_ff == '0) begin
         verdict = clcd_pkg::VERDICT_NONE;
      end else if (cmd_found) begin
         verdict = clcd_pkg::VERDICT_COLOUR;
      end else begin
         verdict = clcd_pkg::VERDICT_UNKNOWN;
      end
   end

   // Edit the line and decide which action, if any, this item makes.
   always_comb begin
      length_in = length_ff;
      overflow_in = overflow_ff;
      skip_in = skip_ff;
      char_wr = 1'b0;
      act_push = 1'b0;
      act_data.kind = clcd_pkg::ACT_ECHO;
      act_data.echo_byte = ch;
      act_data.verdict = verdict;
      act_data.red = lvl_red;
      act_data.green = lvl_green;
      act_data.blue = lvl_blue;
      if (accept) begin
         priority if (req_data.req_type == clcd_pkg::REQ_FLUSH) begin
            length_in = '0;
            overflow_in = 1'b0;
            skip_in = 1'b0;
         end else if (ch == clcd_pkg::CHAR_CR ||
                      (ch == clcd_pkg::CHAR_LF && !skip_ff)) begin
            act_push = 1'b1;
            act_data.kind = clcd_pkg::ACT_END;
            length_in = '0;
            overflow_in = 1'b0;
            skip_in = (ch == clcd_pkg::CHAR_CR);
         end else if (ch == clcd_pkg::CHAR_LF) begin
            // Line feed right after a carriage return is swallowed.
            skip_in = 1'b0;
         end else if (ch == clcd_pkg::CHAR_BS || ch == clcd_pkg::CHAR_DEL) begin
            skip_in = 1'b0;
            if (length_ff != '0) begin
               length_in = length_ff - clcd_pkg::LEN_W'(1);
               act_push = 1'b1;
               act_data.kind = clcd_pkg::ACT_ERASE;
            end
         end else if (ch >= clcd_pkg::CHAR_SPACE && ch <= clcd_pkg::CHAR_TILDE) begin
            skip_in = 1'b0;
            if (length_ff < clcd_pkg::LEN_W'(clcd_pkg::BUFFER_SIZE - 1)) begin
               char_wr = (length_ff < clcd_pkg::LEN_W'(clcd_pkg::STORED_CHARS));
               length_in = length_ff + clcd_pkg::LEN_W'(1);
               act_push = 1'b1;
            end else begin
               // The bell rings only on the first character that does not fit.
               act_push = !overflow_ff;
               act_data.echo_byte = clcd_pkg::CHAR_BEL;
               overflow_in = 1'b1;
            end
         end else begin
            skip_in = 1'b0;
         end
      end
   end

   // Line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         overflow_ff <= 1'b0;
         skip_ff <= 1'b0;
      end else begin
         length_ff <= length_in;
         overflow_ff <= overflow_in;
         skip_ff <= skip_in;
      end
   end

   // Only the first characters of a line are kept.
   always_ff @(posedge clock) begin
      if (char_wr) begin
         chars_ff[length_ff[clcd_pkg::STORE_IDX_W-1:0]] <= ch;
      end
   end

endmodule

// ===== sv/clcd_action_queue.sv =====
module clcd_action_queue (
   input logic clock,
   input logic reset,
   input logic wr_en,
   input clcd_pkg::action_type wr_data,
   output logic full,
   output logic rd_valid,
   output clcd_pkg::action_type rd_data,
   input logic rd_en
);

   clcd_pkg::action_type entry_ff [clcd_pkg::ACT_DEPTH];
   logic [clcd_pkg::ACT_PTR_W-1:0] wr_ptr_ff;
   logic [clcd_pkg::ACT_PTR_W-1:0] rd_ptr_ff;
   logic [clcd_pkg::ACT_CNT_W-1:0] count_ff;
   logic do_wr;
   logic do_rd;

   assign full = (count_ff == clcd_pkg::ACT_CNT_W'(clcd_pkg::ACT_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && rd_valid;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + clcd_pkg::ACT_PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + clcd_pkg::ACT_PTR_W'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + clcd_pkg::ACT_CNT_W'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - clcd_pkg::ACT_CNT_W'(1);
         end
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== sv/clcd_back.sv =====
module clcd_back (
   input logic clock,
   input logic reset,
   input logic act_valid,
   input clcd_pkg::action_type act_data,
   output logic act_pop,
   output logic empty,
   input logic pop,
   output clcd_pkg::rsp_item_type rsp_data
);

   clcd_pkg::rsp_item_type buf_ff [2];
   logic wr_ptr_ff;
   logic rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] step_ff;
   logic [1:0] step_in;
   logic [1:0] last_step;
   logic buf_full;
   logic emit;
   logic do_pop;
   clcd_pkg::rsp_item_type item;

   assign buf_full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign rsp_data = buf_ff[rd_ptr_ff];
   assign emit = act_valid && !buf_full;
   assign do_pop = pop && !empty;

   // Build the result for the current step of the head action.
   always_comb begin
      item.out_kind = clcd_pkg::KIND_ECHO;
      item.echo_byte = '0;
      item.red = '0;
      item.green = '0;
      item.blue = '0;
      last_step = 2'd0;
      unique case (act_data.kind)
         clcd_pkg::ACT_ECHO: begin
            item.echo_byte = act_data.echo_byte;
         end
         clcd_pkg::ACT_ERASE: begin
            last_step = 2'd2;
            item.echo_byte = (step_ff == 2'd1) ? clcd_pkg::CHAR_SPACE : clcd_pkg::CHAR_BS;
         end
         clcd_pkg::ACT_END: begin
            last_step = (act_data.verdict == clcd_pkg::VERDICT_NONE) ? 2'd1 : 2'd2;
            priority if (step_ff == 2'd0) begin
               item.echo_byte = clcd_pkg::CHAR_CR;
            end else if (step_ff == 2'd1) begin
               item.echo_byte = clcd_pkg::CHAR_LF;
            end else begin
               unique case (act_data.verdict)
                  clcd_pkg::VERDICT_COLOUR: begin
                     item.out_kind = clcd_pkg::KIND_COLOUR;
                     item.red = act_data.red;
                     item.green = act_data.green;
                     item.blue = act_data.blue;
                  end
                  clcd_pkg::VERDICT_UNKNOWN: item.out_kind = clcd_pkg::KIND_UNKNOWN;
                  clcd_pkg::VERDICT_REJECT: item.out_kind = clcd_pkg::KIND_REJECT;
                  default: item.out_kind = clcd_pkg::KIND_ECHO;
               endcase
            end
         end
         default: begin
            item.echo_byte = '0;
         end
      endcase
      item.last = (step_ff == last_step);
   end

   // Advance through the steps; the action leaves the queue with its last result.
   always_comb begin
      step_in = step_ff;
      act_pop = 1'b0;
      if (emit) begin
         if (item.last) begin
            step_in = 2'd0;
            act_pop = 1'b1;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   // Step counter and two-entry output buffer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         step_ff <= step_in;
         if (emit) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (emit && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !emit) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Output buffer storage.
   always_ff @(posedge clock) begin
      if (emit) begin
         buf_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== sv/console_line_command_decoder.sv =====
// Console line editor and command decoder. Each received byte or flush request
// is taken whenever the internal action queue has room, so items may arrive
// back to back; the line state is updated at once. Each item makes zero to
// three result transfers (a printable echo or bell makes one, an erase makes
// three, an ended line makes two or three), and the result sequencer emits one
// result per cycle into a two-entry output buffer while an action is queued and
// that buffer has room. When nothing is queued ahead of it, the first result of
// an item passes through the action queue and then the output buffer before it
// reaches the result ports. No clearing pass is needed after reset.
module console_line_command_decoder (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input clcd_pkg::req_item_type req_data,
   output logic empty,
   input logic pop,
   output clcd_pkg::rsp_item_type rsp_data
);

   logic act_push;
   logic act_full;
   logic act_valid;
   logic act_pop;
   clcd_pkg::action_type act_wr_data;
   clcd_pkg::action_type act_rd_data;

   // Line editor and classifier.
   clcd_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .act_push(act_push),
      .act_data(act_wr_data),
      .act_full(act_full)
   );

   // Queue that decouples editing from result delivery.
   clcd_action_queue u_queue (
      .clock(clock),
      .reset(reset),
      .wr_en(act_push),
      .wr_data(act_wr_data),
      .full(act_full),
      .rd_valid(act_valid),
      .rd_data(act_rd_data),
      .rd_en(act_pop)
   );

   // Result sequencer and output buffer.
   clcd_back u_back (
      .clock(clock),
      .reset(reset),
      .act_valid(act_valid),
      .act_data(act_rd_data),
      .act_pop(act_pop),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

`ifndef ASSERT_OFF
   // The editor never pushes an action into a full queue.
   assert property (@(posedge clock) disable iff (reset) act_push |-> !act_full)
      else $error("action pushed into full queue");

   // Colour, unknown and reject results always close out their item.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.out_kind != clcd_pkg::KIND_ECHO) |-> rsp_data.last)
      else $error("command result not marked last");

   // Echo results carry no LED levels.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.out_kind == clcd_pkg::KIND_ECHO) |->
      (rsp_data.red == '0 && rsp_data.green == '0 && rsp_data.blue == '0))
      else $error("echo result carries LED levels");

   // The result side is empty right after reset.
   assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("results present after reset");
`endif

endmodule

// ===== bench/tb_console_line_command_decoder.sv =====
`timescale 1ns / 100ps

module tb_console_line_command_decoder;

   // LED levels that the colour commands select.
   localparam logic [7:0] LED_FULL = 8'hFF;
   localparam logic [7:0] LED_DARK = 8'h00;

   // Steps of the stimulus script.
   typedef enum logic [1:0] {
      STEP_SEND,
      STEP_HOLD,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      clcd_pkg::req_item_type item;
      int unsigned gap;
   } stim_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   clcd_pkg::req_item_type req_data = '0;
   logic empty;
   logic pop = 1'b0;
   clcd_pkg::rsp_item_type rsp_data;

   // Script for the sender and the replies the console should send back.
   stim_step_type pending_steps [$];
   clcd_pkg::rsp_item_type replies_due [$];

   // Line state as the decoder should hold it.
   logic [7:0] line_text [clcd_pkg::STORED_CHARS];
   logic [clcd_pkg::LEN_W-1:0] line_len = '0;
   logic line_overflow = 1'b0;
   logic after_cr = 1'b0;
   clcd_pkg::rsp_item_type reply_batch [3];
   int unsigned batch_count;

   // Sender and receiver state.
   stim_step_type next_step;
   clcd_pkg::req_item_type staged_item;
   logic offering = 1'b0;
   logic loaded = 1'b0;
   int unsigned tx_wait = 0;
   logic tx_calm = 1'b0;
   int unsigned rx_wait = 0;
   int unsigned rx_hold = 0;
   int unsigned rx_hold_request = 0;
   logic rx_calm = 1'b0;

   // Tallies for the report at the end.
   int unsigned counted_items = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned lines_ended = 0;
   int unsigned colour_lines = 0;
   int unsigned unknown_lines = 0;
   int unsigned rejected_lines = 0;
   int unsigned mismatches = 0;

   console_line_command_decoder u_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   // Free-running clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Collect one reply of the item being predicted.
   task automatic add_reply(input logic [1:0] kind, input logic [7:0] ch,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      clcd_pkg::rsp_item_type reply;
      reply.out_kind = kind;
      reply.echo_byte = ch;
      reply.red = r;
      reply.green = g;
      reply.blue = b;
      reply.last = 1'b0;
      reply_batch[batch_count] = reply;
      batch_count++;
   endtask

   // End of line: echo CR LF, then decide what the line meant.
   task automatic close_line();
      logic [55:0] word;
      int unsigned i;
      add_reply(clcd_pkg::KIND_ECHO, clcd_pkg::CHAR_CR, LED_DARK, LED_DARK, LED_DARK);
      add_reply(clcd_pkg::KIND_ECHO, clcd_pkg::CHAR_LF, LED_DARK, LED_DARK, LED_DARK);
      lines_ended++;
      if (line_overflow) begin
         add_reply(clcd_pkg::KIND_REJECT, 8'h00, LED_DARK, LED_DARK, LED_DARK);
         rejected_lines++;
      end else if (line_len != 0) begin
         // Commands are at most seven characters, so only short lines can match.
         word = '0;
         if (line_len <= 7) begin
            for (i = 0; i < line_len; i++) begin
               word = {word[47:0], line_text[i]};
            end
         end
         if (line_len == 6 && word == "LED_ON") begin
            add_reply(clcd_pkg::KIND_COLOUR, 8'h00, LED_FULL, LED_FULL, LED_FULL);
            colour_lines++;
         end else if (line_len == 7 && word == "LED_OFF") begin
            add_reply(clcd_pkg::KIND_COLOUR, 8'h00, LED_DARK, LED_DARK, LED_DARK);
            colour_lines++;
         end else if (line_len == 3 && word == "RED") begin
            add_reply(clcd_pkg::KIND_COLOUR, 8'h00, LED_FULL, LED_DARK, LED_DARK);
            colour_lines++;
         end else if (line_len == 5 && word == "GREEN") begin
            add_reply(clcd_pkg::KIND_COLOUR, 8'h00, LED_DARK, LED_FULL, LED_DARK);
            colour_lines++;
         end else if (line_len == 4 && word == "BLUE") begin
            add_reply(clcd_pkg::KIND_COLOUR, 8'h00, LED_DARK, LED_DARK, LED_FULL);
            colour_lines++;
         end else begin
            add_reply(clcd_pkg::KIND_UNKNOWN, 8'h00, LED_DARK, LED_DARK, LED_DARK);
            unknown_lines++;
         end
      end
      line_len = '0;
      line_overflow = 1'b0;
   endtask

   // Apply one accepted item to the line and queue the replies it causes.
   task automatic edit_line(input clcd_pkg::req_item_type item);
      clcd_pkg::rsp_item_type reply;
      int unsigned i;
      batch_count = 0;
      if (item.req_type == clcd_pkg::REQ_FLUSH) begin
         line_len = '0;
         line_overflow = 1'b0;
         after_cr = 1'b0;
      end else if (item.rx_byte == clcd_pkg::CHAR_CR) begin
         close_line();
         after_cr = 1'b1;
      end else if (item.rx_byte == clcd_pkg::CHAR_LF) begin
         // An LF right after a CR is the second half of the same line end.
         if (after_cr) begin
            after_cr = 1'b0;
         end else begin
            close_line();
         end
      end else begin
         after_cr = 1'b0;
         if (item.rx_byte == clcd_pkg::CHAR_BS || item.rx_byte == clcd_pkg::CHAR_DEL) begin
            if (line_len != 0) begin
               line_len--;
               add_reply(clcd_pkg::KIND_ECHO, clcd_pkg::CHAR_BS,
                         LED_DARK, LED_DARK, LED_DARK);
               add_reply(clcd_pkg::KIND_ECHO, clcd_pkg::CHAR_SPACE,
                         LED_DARK, LED_DARK, LED_DARK);
               add_reply(clcd_pkg::KIND_ECHO, clcd_pkg::CHAR_BS,
                         LED_DARK, LED_DARK, LED_DARK);
            end
         end else if (item.rx_byte >= clcd_pkg::CHAR_SPACE &&
                      item.rx_byte <= clcd_pkg::CHAR_TILDE) begin
            if (line_len < clcd_pkg::BUFFER_SIZE - 1) begin
               if (line_len < clcd_pkg::STORED_CHARS) begin
                  line_text[line_len[clcd_pkg::STORE_IDX_W-1:0]] = item.rx_byte;
               end
               line_len++;
               add_reply(clcd_pkg::KIND_ECHO, item.rx_byte, LED_DARK, LED_DARK, LED_DARK);
            end else begin
               // A full line rings the bell once and then drops characters.
               if (!line_overflow) begin
                  add_reply(clcd_pkg::KIND_ECHO, clcd_pkg::CHAR_BEL,
                            LED_DARK, LED_DARK, LED_DARK);
               end
               line_overflow = 1'b1;
            end
         end
      end
      for (i = 0; i < batch_count; i++) begin
         reply = reply_batch[i];
         reply.last = (i == batch_count - 1);
         replies_due.push_back(reply);
      end
   endtask

   // Compare one reply with the oldest one due.
   task automatic check_reply(input clcd_pkg::rsp_item_type got);
      clcd_pkg::rsp_item_type want;
      if (replies_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected result: kind %0d byte %02h rgb %02h %02h %02h last %0d",
                     got.out_kind, got.echo_byte, got.red, got.green, got.blue, got.last);
         end
      end else begin
         want = replies_due.pop_front();
         results_checked++;
         if (got.out_kind !== want.out_kind || got.echo_byte !== want.echo_byte ||
             got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display({"mismatch at result %0d: expected kind %0d byte %02h ",
                         "rgb %02h %02h %02h last %0d"},
                        results_checked, want.out_kind, want.echo_byte, want.red,
                        want.green, want.blue, want.last);
               $display("   actual: kind %0d byte %02h rgb %02h %02h %02h last %0d",
                        got.out_kind, got.echo_byte, got.red, got.green, got.blue,
                        got.last);
            end
         end
      end
   endtask

   // Sender: offers scripted items, predicting the replies at each transfer.
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         loaded = 1'b0;
         tx_wait = 0;
         line_len = '0;
         line_overflow = 1'b0;
         after_cr = 1'b0;
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            edit_line(req_data);
            items_sent++;
            offering = 1'b0;
         end
         if (!offering && !loaded && pending_steps.size() != 0) begin
            case (pending_steps[0].kind)
               STEP_DRAIN: begin
                  if (replies_due.size() == 0) begin
                     next_step = pending_steps.pop_front();
                  end
               end
               STEP_HOLD: begin
                  next_step = pending_steps.pop_front();
                  rx_hold_request = next_step.gap;
               end
               STEP_SEND: begin
                  next_step = pending_steps.pop_front();
                  staged_item = next_step.item;
                  tx_wait = next_step.gap;
                  loaded = 1'b1;
               end
               default: begin
                  next_step = pending_steps.pop_front();
               end
            endcase
         end
         if (loaded) begin
            if (tx_wait != 0) begin
               tx_wait--;
            end else begin
               loaded = 1'b0;
               offering = 1'b1;
               req_data <= staged_item;
            end
         end
         push <= offering;
      end
   end

   // Receiver: checks each transfer and stalls at random or on request.
   always @(posedge clock) begin
      if (reset) begin
         rx_wait = 0;
         rx_hold = 0;
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            check_reply(rsp_data);
            rx_wait = rx_calm ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0) begin
               rx_calm = !rx_calm;
            end
         end
         if (rx_hold_request != 0) begin
            rx_hold = rx_hold_request;
            rx_hold_request = 0;
         end
         if (rx_hold != 0) begin
            rx_hold--;
            pop <= 1'b0;
         end else if (rx_wait != 0) begin
            rx_wait--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Script building.
   task automatic queue_step(input step_kind_type kind, input int unsigned gap);
      stim_step_type s;
      s.kind = kind;
      s.item = '0;
      s.gap = gap;
      pending_steps.push_back(s);
   endtask

   task automatic queue_item(input clcd_pkg::req_item_type item, input bit counts);
      stim_step_type s;
      s.kind = STEP_SEND;
      s.item = item;
      s.gap = tx_calm ? 0 : $urandom_range(0, 12);
      pending_steps.push_back(s);
      if (counts) begin
         counted_items++;
      end
   endtask

   task automatic queue_byte(input logic [7:0] b);
      clcd_pkg::req_item_type item;
      item.req_type = clcd_pkg::REQ_BYTE;
      item.rx_byte = b;
      queue_item(item, 1'b1);
   endtask

   task automatic queue_text(input string text);
      int i;
      for (i = 0; i < text.len(); i++) begin
         queue_byte(text[i]);
      end
   endtask

   task automatic queue_flush();
      clcd_pkg::req_item_type item;
      item.req_type = clcd_pkg::REQ_FLUSH;
      item.rx_byte = $urandom_range(0, 255);
      queue_item(item, 1'b1);
   endtask

   function automatic logic [7:0] any_printable();
      return 8'($urandom_range(clcd_pkg::CHAR_SPACE, clcd_pkg::CHAR_TILDE));
   endfunction

   function automatic logic [7:0] any_erase();
      return $urandom_range(0, 1) ? clcd_pkg::CHAR_BS : clcd_pkg::CHAR_DEL;
   endfunction

   function automatic string command_text(input int unsigned idx);
      case (idx)
         0: return "LED_ON";
         1: return "LED_OFF";
         2: return "RED";
         3: return "GREEN";
         default: return "BLUE";
      endcase
   endfunction

   // Lines end with CR, LF, CR LF, two LFs, or are thrown away by a flush.
   task automatic queue_line_end();
      case ($urandom_range(0, 5))
         0, 1: queue_byte(clcd_pkg::CHAR_CR);
         2: queue_byte(clcd_pkg::CHAR_LF);
         3: begin
            queue_byte(clcd_pkg::CHAR_CR);
            queue_byte(clcd_pkg::CHAR_LF);
         end
         4: begin
            queue_byte(clcd_pkg::CHAR_LF);
            queue_byte(clcd_pkg::CHAR_LF);
         end
         default: queue_flush();
      endcase
   endtask

   // A long line that may run past the buffer, sometimes with erasing at its end.
   task automatic queue_long_line(input int unsigned min_len);
      int unsigned n;
      int unsigned k;
      int unsigned i;
      n = $urandom_range(min_len, 70);
      for (i = 0; i < n; i++) begin
         queue_byte(any_printable());
      end
      if ($urandom_range(0, 1) == 1) begin
         k = $urandom_range(1, 3);
         for (i = 0; i < k; i++) begin
            queue_byte(any_erase());
         end
         k = $urandom_range(0, 5);
         for (i = 0; i < k; i++) begin
            queue_byte(any_printable());
         end
      end
      queue_line_end();
   endtask

   // One random line: many commands, some garbled, short, erased or noisy.
   task automatic queue_random_line();
      int unsigned sel;
      int unsigned n;
      int unsigned k;
      int unsigned i;
      string text;
      sel = $urandom_range(0, 23);
      if ($urandom_range(0, 7) == 0) begin
         tx_calm = !tx_calm;
      end
      if (sel < 10) begin
         text = command_text($urandom_range(0, 4));
         if ($urandom_range(0, 4) == 0) begin
            text[$urandom_range(0, text.len() - 1)] = any_printable();
         end
         // A typo that is erased again partway through the word.
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, text.len() - 1) : 99;
         for (i = 0; i < text.len(); i++) begin
            if (i == n) begin
               queue_byte(any_printable());
               queue_byte(any_erase());
            end
            queue_byte(text[i]);
         end
         queue_line_end();
      end else if (sel < 16) begin
         n = $urandom_range(0, 11);
         for (i = 0; i < n; i++) begin
            queue_byte(any_printable());
            if ($urandom_range(0, 5) == 0) begin
               queue_byte(any_erase());
            end
         end
         queue_line_end();
      end else if (sel == 16) begin
         queue_long_line(58);
      end else if (sel < 19) begin
         // Random bytes of any value, not counted as items, sometimes followed by a flush.
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) begin
            queue_item('{req_type: clcd_pkg::REQ_BYTE, rx_byte: 8'($urandom_range(0, 255))},
                       1'b0);
         end
         if ($urandom_range(0, 2) == 0) begin
            queue_flush();
         end
      end else if (sel < 21) begin
         n = $urandom_range(0, 5);
         for (i = 0; i < n; i++) begin
            queue_byte(any_printable());
         end
         k = n + $urandom_range(0, 2);
         for (i = 0; i < k; i++) begin
            queue_byte(any_erase());
         end
         queue_line_end();
      end else begin
         // Prefix of a command, or a command with one character too many.
         text = command_text($urandom_range(0, 4));
         n = $urandom_range(1, text.len() - 1);
         if ($urandom_range(0, 1) == 1) begin
            for (i = 0; i < n; i++) begin
               queue_byte(text[i]);
            end
         end else begin
            queue_text(text);
            queue_byte(any_printable());
         end
         queue_line_end();
      end
   endtask

   // Script, reset and the end of the run.
   initial begin
      // Directed lines: colour commands, every kind of line end, erasing,
      // ignored bytes at both ends of the byte range and a flush.
      queue_text("RED");
      queue_byte(clcd_pkg::CHAR_CR);
      queue_byte(clcd_pkg::CHAR_LF);
      queue_text("BLUE");
      queue_byte(clcd_pkg::CHAR_LF);
      queue_byte(clcd_pkg::CHAR_CR);
      queue_byte(clcd_pkg::CHAR_BS);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_flush();
      queue_text("LED_OFX");
      queue_byte(clcd_pkg::CHAR_DEL);
      queue_text("F");
      queue_byte(clcd_pkg::CHAR_CR);
      queue_text("X");
      queue_byte(clcd_pkg::CHAR_CR);
      queue_step(STEP_DRAIN, 0);

      // Receiver holds off while the sender pushes a full line back to back.
      queue_step(STEP_HOLD, 160);
      tx_calm = 1'b1;
      queue_long_line(64);
      tx_calm = 1'b0;
      while (counted_items < 160) begin
         queue_random_line();
      end

      // Sender pauses until every reply is in, then a second hold-off.
      queue_step(STEP_DRAIN, 0);
      queue_step(STEP_HOLD, 120);
      tx_calm = 1'b1;
      queue_text("GREEN");
      queue_byte(clcd_pkg::CHAR_CR);
      queue_text("LED_ON");
      queue_byte(clcd_pkg::CHAR_CR);
      tx_calm = 1'b0;
      while (counted_items < 320) begin
         queue_random_line();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_steps.size() != 0 || loaded || offering) begin
         @(posedge clock);
      end
      while (replies_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);

      if (replies_due.size() != 0) begin
         mismatches += replies_due.size();
         $display("%0d expected results never arrived", replies_due.size());
      end
      $display("Sent %0d items and checked %0d results over %0d ended lines",
               items_sent, results_checked, lines_ended);
      $display("Lines decoded: %0d colour, %0d unknown, %0d rejected as too long",
               colour_lines, unknown_lines, rejected_lines);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
